FILE: design/ppmkd_pkg.sv
package ppmkd_pkg;

    localparam int MAX_DIM_DEFAULT = 4096;

    // Field widths of the result stream.
    localparam int OUT_DIM_W = 13;
    localparam int COLOR_W   = 8;
    localparam int KIND_W    = 2;
    localparam int CODE_W    = 2;
    localparam int TDATA_W   = 64;

    // The decimal accumulator saturates at 65536, so it needs 17 bits.
    localparam int ACC_W   = 17;
    localparam int ACC_CAP = 65536;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration port.
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_RED   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_GREEN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_BLUE  = 2'd2;

    localparam logic [COLOR_W-1:0] KEY_RED_RESET   = 8'd255;
    localparam logic [COLOR_W-1:0] KEY_GREEN_RESET = 8'd0;
    localparam logic [COLOR_W-1:0] KEY_BLUE_RESET  = 8'd255;

    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

    localparam logic [CODE_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] ERR_MAGIC  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_MAXVAL = 2'd2;
    localparam logic [CODE_W-1:0] ERR_NUMBER = 2'd3;

    // One classified request travelling from the parser to the output side.
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CODE_W-1:0]    error_code;
        logic [OUT_DIM_W-1:0] image_width;
        logic [OUT_DIM_W-1:0] image_height;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic                 last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

FILE: design/ppmkd_front.sv
module ppmkd_front import ppmkd_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_data,
    input  logic         i_file_start,
    input  t_fifo_status i_status,
    output logic         o_ready,
    output logic         o_push,
    output t_item        o_item
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int SUM_W = ACC_W + 4;

    localparam logic [3:0] PH_MAGIC1  = 4'd0;
    localparam logic [3:0] PH_MAGIC2  = 4'd1;
    localparam logic [3:0] PH_SEP     = 4'd2;
    localparam logic [3:0] PH_HASH    = 4'd3;
    localparam logic [3:0] PH_COMMENT = 4'd4;
    localparam logic [3:0] PH_WIDTH   = 4'd5;
    localparam logic [3:0] PH_HEIGHT  = 4'd6;
    localparam logic [3:0] PH_MAXVAL  = 4'd7;
    localparam logic [3:0] PH_PIXELS  = 4'd8;
    localparam logic [3:0] PH_IDLE    = 4'd9;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] MAXVAL_OK = 8'd255;

    logic [3:0]       r_phase, n_phase;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_seen, n_seen;
    logic [DIM_W-1:0] r_width, n_width;
    logic [DIM_W-1:0] r_height, n_height;
    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [1:0]       r_slot, n_slot;
    logic [7:0]       r_red, n_red;
    logic [7:0]       r_green, n_green;

    logic [3:0]       w_ph;
    logic [3:0]       w_num_ph;
    logic [ACC_W-1:0] w_acc;
    logic             w_seen;
    logic             w_accept;
    logic             w_is_digit;
    logic             w_is_space;
    logic             w_do_num;
    logic [SUM_W-1:0] w_sum;
    logic [ACC_W-1:0] w_acc_next;
    logic             w_pix_last;
    logic             w_empty_img;

    assign o_ready  = !i_status.full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        // A file start restarts the parser on this very byte.
        w_ph   = i_file_start ? PH_MAGIC1 : r_phase;
        w_acc  = i_file_start ? '0 : r_acc;
        w_seen = i_file_start ? 1'b0 : r_seen;

        w_is_digit = (i_data >= CH_0) && (i_data <= CH_9);
        w_is_space = (i_data == CH_SPACE) || (i_data == CH_TAB) ||
                     (i_data == CH_LF) || (i_data == CH_CR);
        w_sum = (SUM_W'(w_acc) << 3) + (SUM_W'(w_acc) << 1) +
                SUM_W'(i_data - CH_0);
        w_acc_next = (w_sum > SUM_W'(ACC_CAP)) ? ACC_W'(ACC_CAP) : w_sum[ACC_W-1:0];

        w_num_ph = (w_ph == PH_HASH) ? PH_WIDTH : w_ph;
        w_do_num = ((w_ph == PH_HASH) && (i_data != CH_HASH)) ||
                   (w_ph == PH_WIDTH) || (w_ph == PH_HEIGHT) || (w_ph == PH_MAXVAL);

        w_pix_last = (({1'b0, r_col} + 1'b1) == {1'b0, r_width}) &&
                     (({1'b0, r_row} + 1'b1) == {1'b0, r_height});
        w_empty_img = (r_width == '0) || (r_height == '0);

        n_phase  = r_phase;
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_slot   = r_slot;
        n_red    = r_red;
        n_green  = r_green;
        o_push   = 1'b0;
        o_item   = '0;

        if (w_accept) begin
            n_phase = w_ph;
            n_acc   = w_acc;
            n_seen  = w_seen;
            if (w_do_num) begin
                n_phase = w_num_ph;
                if (w_is_digit) begin
                    n_acc  = w_acc_next;
                    n_seen = 1'b1;
                    if ((w_num_ph != PH_MAXVAL) && (w_acc_next > ACC_W'(MAX_DIM))) begin
                        o_push            = 1'b1;
                        o_item.kind       = KIND_ERROR;
                        o_item.error_code = ERR_NUMBER;
                        n_phase           = PH_IDLE;
                    end
                end else if (!w_is_space) begin
                    o_push            = 1'b1;
                    o_item.kind       = KIND_ERROR;
                    o_item.error_code = ERR_NUMBER;
                    n_phase           = PH_IDLE;
                end else if (w_seen) begin
                    n_acc  = '0;
                    n_seen = 1'b0;
                    unique case (w_num_ph)
                        PH_WIDTH: begin
                            n_width = w_acc[DIM_W-1:0];
                            n_phase = PH_HEIGHT;
                        end
                        PH_HEIGHT: begin
                            n_height = w_acc[DIM_W-1:0];
                            n_phase  = PH_MAXVAL;
                        end
                        default: begin
                            o_push = 1'b1;
                            if (w_acc != ACC_W'(MAXVAL_OK)) begin
                                o_item.kind       = KIND_ERROR;
                                o_item.error_code = ERR_MAXVAL;
                                n_phase           = PH_IDLE;
                            end else begin
                                o_item.kind         = KIND_HEADER;
                                o_item.image_width  = OUT_DIM_W'(r_width);
                                o_item.image_height = OUT_DIM_W'(r_height);
                                o_item.last         = w_empty_img;
                                n_col   = '0;
                                n_row   = '0;
                                n_slot  = '0;
                                n_phase = w_empty_img ? PH_IDLE : PH_PIXELS;
                            end
                        end
                    endcase
                end
            end else begin
                unique case (w_ph)
                    PH_MAGIC1: begin
                        if (i_data != CH_P) begin
                            o_push            = 1'b1;
                            o_item.kind       = KIND_ERROR;
                            o_item.error_code = ERR_MAGIC;
                            n_phase           = PH_IDLE;
                        end else begin
                            n_phase = PH_MAGIC2;
                        end
                    end
                    PH_MAGIC2: begin
                        if (i_data != CH_6) begin
                            o_push            = 1'b1;
                            o_item.kind       = KIND_ERROR;
                            o_item.error_code = ERR_MAGIC;
                            n_phase           = PH_IDLE;
                        end else begin
                            n_phase = PH_SEP;
                        end
                    end
                    PH_SEP: begin
                        n_phase = PH_HASH;
                    end
                    PH_HASH: begin
                        n_phase = PH_COMMENT;
                    end
                    PH_COMMENT: begin
                        if (i_data == CH_LF) begin
                            n_phase = PH_WIDTH;
                        end
                    end
                    PH_PIXELS: begin
                        unique case (r_slot)
                            2'd0: begin
                                n_red  = i_data;
                                n_slot = 2'd1;
                            end
                            2'd1: begin
                                n_green = i_data;
                                n_slot  = 2'd2;
                            end
                            default: begin
                                n_slot       = 2'd0;
                                o_push       = 1'b1;
                                o_item.kind  = KIND_PIXEL;
                                o_item.red   = r_red;
                                o_item.green = r_green;
                                o_item.blue  = i_data;
                                o_item.last  = w_pix_last;
                                if (w_pix_last) begin
                                    n_phase = PH_IDLE;
                                end else if (({1'b0, r_col} + 1'b1) == {1'b0, r_width}) begin
                                    n_col = '0;
                                    n_row = r_row + 1'b1;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                        endcase
                    end
                    default: begin
                        n_phase = w_ph;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC1;
            r_acc   <= '0;
            r_seen  <= 1'b0;
            r_slot  <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_slot  <= n_slot;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_width  <= n_width;
        r_height <= n_height;
        r_red    <= n_red;
        r_green  <= n_green;
    end

endmodule

FILE: design/ppmkd_fifo.sv
module ppmkd_fifo import ppmkd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_item        i_item,
    input  logic         i_pop,
    output t_item        o_item,
    output t_fifo_status o_status
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/ppmkd_back.sv
module ppmkd_back import ppmkd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_item              i_item,
    input  t_fifo_status       i_status,
    output logic               o_pop,
    input  logic [COLOR_W-1:0] i_key_red,
    input  logic [COLOR_W-1:0] i_key_green,
    input  logic [COLOR_W-1:0] i_key_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TDATA_W-1:0] o_tdata,
    output logic [KIND_W-1:0]  o_tuser,
    output logic               o_tlast
);

    logic               r_valid;
    logic [TDATA_W-1:0] r_tdata;
    logic [KIND_W-1:0]  r_tuser;
    logic               r_tlast;

    logic               w_match;
    logic               w_show;
    logic [COLOR_W-1:0] w_red;
    logic [COLOR_W-1:0] w_green;
    logic [COLOR_W-1:0] w_blue;
    logic [COLOR_W-1:0] w_alpha;
    logic [TDATA_W-1:0] w_tdata;

    assign o_pop   = !i_status.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_tdata = r_tdata;
    assign o_tuser = r_tuser;
    assign o_tlast = r_tlast;

    always_comb begin
        w_match = (i_item.red == i_key_red) && (i_item.green == i_key_green) &&
                  (i_item.blue == i_key_blue);
        // Keyed pixels and non-pixel results carry all-zero color.
        w_show  = (i_item.kind == KIND_PIXEL) && !w_match;
        w_red   = w_show ? i_item.red : '0;
        w_green = w_show ? i_item.green : '0;
        w_blue  = w_show ? i_item.blue : '0;
        w_alpha = w_show ? {COLOR_W{1'b1}} : '0;
        w_tdata = TDATA_W'({w_alpha, w_blue, w_green, w_red, i_item.image_height,
                            i_item.image_width, i_item.error_code});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tdata <= w_tdata;
            r_tuser <= i_item.kind;
            r_tlast <= i_item.last;
        end
    end

endmodule

FILE: design/ppm_p6_colorkey_decoder.sv
// Binary PPM (P6) decoder with a transparent color key.
// Input stream: one file byte per request. s_axis_tdata carries the byte and
// s_axis_tuser marks the first byte of a new file, which restarts the parser.
// Output stream: one result per header, pixel or error. m_axis_tuser gives the
// kind (pixel, header, error), m_axis_tlast marks the final pixel, or the
// header of an empty image. Pixels equal to the key read as all zeros.
// The key is set through the APB port at byte addresses 0, 4 and 8 (red,
// green, blue) and should only be written while the stream is idle.
// Throughput is one byte per cycle while the result queue has room; the parser
// updates its state in the same cycle it takes a byte. A result that a byte
// completes passes through the result queue and then the output register.
// A four-entry queue sits between parser and output stage, so a stalled
// receiver only holds off input once the queue and output register are full.
// Reset returns the parser to expect the "P6" magic, empties the queue and
// loads the key with magenta (255, 0, 255).
module ppm_p6_colorkey_decoder import ppmkd_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tuser,   // [0] file_start
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [1:0] error_code, [14:2] image_width, [27:15] image_height, [35:28] red,
    // [43:36] green, [51:44] blue, [59:52] alpha, [63:60] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]  m_axis_tuser,   // [1:0] kind
    output logic               m_axis_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [COLOR_W-1:0]   r_key_red;
    logic [COLOR_W-1:0]   r_key_green;
    logic [COLOR_W-1:0]   r_key_blue;
    logic [REG_IDX_W-1:0] w_reg_idx;

    logic         w_push;
    t_item        w_push_item;
    logic         w_pop;
    t_item        w_pop_item;
    t_fifo_status w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        unique case (w_reg_idx)
            REG_KEY_RED:   prdata = 32'(r_key_red);
            REG_KEY_GREEN: prdata = 32'(r_key_green);
            REG_KEY_BLUE:  prdata = 32'(r_key_blue);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_red   <= KEY_RED_RESET;
            r_key_green <= KEY_GREEN_RESET;
            r_key_blue  <= KEY_BLUE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg_idx)
                REG_KEY_RED:   r_key_red   <= pwdata[COLOR_W-1:0];
                REG_KEY_GREEN: r_key_green <= pwdata[COLOR_W-1:0];
                REG_KEY_BLUE:  r_key_blue  <= pwdata[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppmkd_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .i_file_start (s_axis_tuser),
        .i_status     (w_status),
        .o_ready      (s_axis_tready),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    ppmkd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_pop_item),
        .o_status (w_status)
    );

    ppmkd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_pop_item),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .i_key_red   (r_key_red),
        .i_key_green (r_key_green),
        .i_key_blue  (r_key_blue),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

    // The parser never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_status.full))
        else $error("result queue written while full");

    // The output stage only takes from a queue that holds something.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_status.empty))
        else $error("result queue read while empty");

    // Whatever leaves the queue shows up on the output in the next cycle.
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> m_axis_tvalid)
        else $error("popped result not presented");

    // A keyed pixel must come out fully transparent and black.
    a_keyed_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_PIXEL) && (m_axis_tdata[59:52] == '0))
        |-> (m_axis_tdata[51:28] == '0))
        else $error("transparent pixel carries color");

endmodule

FILE: bench/ppm_p6_colorkey_decoder_test.sv
module ppm_p6_colorkey_decoder_test;
    import ppmkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int MAXVAL_OK    = 255;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_PHASES = 6;
    localparam int BYTES_PER_PHASE = 165;
    localparam int FORCED_WIDTH = 96;

    typedef enum logic [3:0] {
        PS_MAGIC_P, PS_MAGIC_6, PS_SEPARATOR, PS_HASH_CHECK, PS_COMMENT,
        PS_WIDTH, PS_HEIGHT, PS_MAXVAL, PS_PIXELS, PS_IGNORE
    } t_parse_state;

    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} t_pace;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CODE_W-1:0]    code;
        logic [OUT_DIM_W-1:0] width;
        logic [OUT_DIM_W-1:0] height;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COLOR_W-1:0]   alpha;
        logic                 last;
    } t_rgba_result;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } t_file_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'd0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]  m_axis_tuser;
    logic               m_axis_tlast;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    ppm_p6_colorkey_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Decoder state mirrored on the bench side.
    logic [7:0]   color_key [3];
    t_parse_state pstate;
    int           acc;
    bit           seen_digit;
    int           width_v;
    int           height_v;
    int           pixels_left;
    int           slot;
    logic [7:0]   held_r;
    logic [7:0]   held_g;

    t_file_byte   file_bytes [$];
    t_rgba_result rgba_expect [$];

    t_pace send_pace = PACE_FULL;
    t_pace recv_pace = PACE_FULL;
    bit    hold_go = 1'b0;
    logic  rx_hold = 1'b0;

    int bytes_made = 0;
    int bytes_taken = 0;
    int mismatches = 0;
    int n_headers = 0;
    int n_pixels = 0;
    int n_keyed = 0;
    int n_errors = 0;
    int key_settings = 1;

    function automatic int pace_wait(input t_pace p);
        case (p)
            PACE_RANDOM: return $urandom_range(0, 19);
            PACE_BURSTY: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic string describe(input t_rgba_result r);
        return $sformatf("kind=%0d code=%0d w=%0d h=%0d rgba=%h_%h_%h_%h last=%0d",
                         r.kind, r.code, r.width, r.height,
                         r.red, r.green, r.blue, r.alpha, r.last);
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, what);
    endtask

    task automatic restart_parser();
        pstate = PS_MAGIC_P;
        acc = 0;
        seen_digit = 1'b0;
        width_v = 0;
        height_v = 0;
        pixels_left = 0;
        slot = 0;
        held_r = 8'd0;
        held_g = 8'd0;
    endtask

    task automatic raise_error(input logic [CODE_W-1:0] code, output bit got,
                               inout t_rgba_result r);
        r.kind = KIND_ERROR;
        r.code = code;
        got = 1'b1;
        pstate = PS_IGNORE;
    endtask

    // One byte of a decimal header field.
    task automatic number_byte(input logic [7:0] b, output bit got, inout t_rgba_result r);
        int v;
        got = 1'b0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            acc = acc * 10 + int'(b - CH_ZERO);
            if (acc > ACC_CAP)
                acc = ACC_CAP;
            seen_digit = 1'b1;
            if (pstate != PS_MAXVAL && acc > MAX_DIM_DEFAULT)
                raise_error(ERR_NUMBER, got, r);
        end else if (!is_blank(b)) begin
            raise_error(ERR_NUMBER, got, r);
        end else if (seen_digit) begin
            v = acc;
            acc = 0;
            seen_digit = 1'b0;
            case (pstate)
                PS_WIDTH: begin
                    width_v = v;
                    pstate = PS_HEIGHT;
                end
                PS_HEIGHT: begin
                    height_v = v;
                    pstate = PS_MAXVAL;
                end
                default: begin
                    if (v != MAXVAL_OK) begin
                        raise_error(ERR_MAXVAL, got, r);
                    end else begin
                        pixels_left = width_v * height_v;
                        slot = 0;
                        got = 1'b1;
                        r.kind = KIND_HEADER;
                        r.width = OUT_DIM_W'(width_v);
                        r.height = OUT_DIM_W'(height_v);
                        r.last = (pixels_left == 0);
                        pstate = (pixels_left == 0) ? PS_IGNORE : PS_PIXELS;
                    end
                end
            endcase
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start,
                               output bit got, output t_rgba_result r);
        got = 1'b0;
        r = '0;
        if (start)
            restart_parser();
        case (pstate)
            PS_MAGIC_P: begin
                if (b != CH_P)
                    raise_error(ERR_MAGIC, got, r);
                else
                    pstate = PS_MAGIC_6;
            end
            PS_MAGIC_6: begin
                if (b != CH_6)
                    raise_error(ERR_MAGIC, got, r);
                else
                    pstate = PS_SEPARATOR;
            end
            PS_SEPARATOR: pstate = PS_HASH_CHECK;
            PS_HASH_CHECK: begin
                if (b == CH_HASH) begin
                    pstate = PS_COMMENT;
                end else begin
                    // Anything else already belongs to the width field.
                    pstate = PS_WIDTH;
                    number_byte(b, got, r);
                end
            end
            PS_COMMENT: begin
                if (b == CH_LF)
                    pstate = PS_WIDTH;
            end
            PS_WIDTH, PS_HEIGHT, PS_MAXVAL: number_byte(b, got, r);
            PS_PIXELS: begin
                if (slot == 0) begin
                    held_r = b;
                    slot = 1;
                end else if (slot == 1) begin
                    held_g = b;
                    slot = 2;
                end else begin
                    slot = 0;
                    got = 1'b1;
                    r.kind = KIND_PIXEL;
                    if (!(held_r == color_key[REG_KEY_RED] &&
                          held_g == color_key[REG_KEY_GREEN] &&
                          b == color_key[REG_KEY_BLUE])) begin
                        r.red = held_r;
                        r.green = held_g;
                        r.blue = b;
                        r.alpha = 8'hFF;
                    end
                    if (pixels_left > 0)
                        pixels_left--;
                    if (pixels_left == 0) begin
                        r.last = 1'b1;
                        pstate = PS_IGNORE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Sender: one request per byte, with a drawn gap before the next one.
    int           send_gap = 0;
    bit           byte_has_result;
    t_rgba_result byte_result;
    t_file_byte   next_byte;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tuser, byte_has_result, byte_result);
                if (byte_has_result)
                    rgba_expect.push_back(byte_result);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (file_bytes.size() > 0) begin
                    next_byte = file_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_byte.data;
                    s_axis_tuser <= next_byte.start;
                    send_gap = pace_wait(send_pace);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result and, at a drawn pace, stalls between them.
    int           rx_wait = 0;
    t_rgba_result seen;
    t_rgba_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.kind = m_axis_tuser;
                seen.code = m_axis_tdata[1:0];
                seen.width = m_axis_tdata[14:2];
                seen.height = m_axis_tdata[27:15];
                seen.red = m_axis_tdata[35:28];
                seen.green = m_axis_tdata[43:36];
                seen.blue = m_axis_tdata[51:44];
                seen.alpha = m_axis_tdata[59:52];
                seen.last = m_axis_tlast;
                if (rgba_expect.size() == 0) begin
                    note_mismatch({"unexpected result: ", describe(seen)});
                end else begin
                    want = rgba_expect.pop_front();
                    if (seen !== want || m_axis_tdata[TDATA_W-1:60] !== '0)
                        note_mismatch({"expected ", describe(want), "\n    got ",
                                       describe(seen),
                                       $sformatf(" pad=%h", m_axis_tdata[TDATA_W-1:60])});
                    case (want.kind)
                        KIND_HEADER: n_headers++;
                        KIND_ERROR:  n_errors++;
                        default: begin
                            n_pixels++;
                            if (want.alpha == 8'd0)
                                n_keyed++;
                        end
                    endcase
                end
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                rx_wait = pace_wait(recv_pace);
                m_axis_tready <= (rx_wait == 0);
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= (rx_wait == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver stall while the sender keeps streaming pixels.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    task automatic apb_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [7:0] wval, output logic [31:0] rval);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, wval};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rval = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic verify_key_regs();
        logic [31:0] rd;
        for (int i = 0; i < 3; i++) begin
            apb_access(1'b0, REG_IDX_W'(i), 8'd0, rd);
            if (rd !== {24'd0, color_key[i]})
                note_mismatch($sformatf("key register %0d reads %h, expected %h",
                                        i, rd, color_key[i]));
        end
    endtask

    task automatic set_color_key(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        logic [31:0] rd_dummy;
        apb_access(1'b1, REG_KEY_RED, r, rd_dummy);
        color_key[REG_KEY_RED] = r;
        apb_access(1'b1, REG_KEY_GREEN, g, rd_dummy);
        color_key[REG_KEY_GREEN] = g;
        apb_access(1'b1, REG_KEY_BLUE, b, rd_dummy);
        color_key[REG_KEY_BLUE] = b;
        key_settings++;
        verify_key_regs();
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start);
        t_file_byte fb;
        fb.data = b;
        fb.start = start;
        file_bytes.push_back(fb);
        bytes_made++;
    endtask

    task automatic push_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], start && i == 0);
    endtask

    task automatic push_blank();
        case ($urandom_range(0, 3))
            0: push_byte(CH_SPACE, 1'b0);
            1: push_byte(CH_TAB, 1'b0);
            2: push_byte(CH_LF, 1'b0);
            default: push_byte(CH_CR, 1'b0);
        endcase
    endtask

    task automatic push_decimal(input int v);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) push_byte(CH_ZERO, 1'b0);
        push_text($sformatf("%0d", v), 1'b0);
    endtask

    // Random bytes at a file's end; after an error or a whole image they are dropped.
    task automatic push_noise();
        repeat ($urandom_range(1, 4))
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic logic [7:0] bad_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_blank(b) || (b >= CH_ZERO && b <= CH_NINE));
        return b;
    endfunction

    // One file: mostly well formed with random content, otherwise broken in
    // one of several ways. A forced width gives a clean width x 1 image.
    task automatic make_file(input int forced_w);
        int         flavor;
        int         pick;
        int         w;
        int         h;
        int         t;
        int         maxv;
        int         n;
        int         cut;
        logic [7:0] trip [3];
        logic [7:0] b;
        flavor = (forced_w >= 0) ? 99 : $urandom_range(0, 99);
        if (flavor < 5) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end else if (flavor < 9) begin
            push_byte(CH_P, 1'b1);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (flavor < 14) begin
            // Cut short inside the header; the next file restarts the parser.
            push_text("P6", 1'b1);
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                w = $urandom_range(0, 4);
                h = $urandom_range(0, 4);
            end else if (pick < 86) begin
                w = $urandom_range(5, 40);
                h = $urandom_range(1, 2);
            end else if (pick < 93) begin
                w = MAX_DIM_DEFAULT - $urandom_range(0, 1);
                h = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: w = MAX_DIM_DEFAULT + 1;
                    1: w = MAX_DIM_DEFAULT + $urandom_range(2, 5000);
                    2: w = ACC_CAP;
                    default: w = 9999999;
                endcase
                h = 1;
            end
            if (pick >= 70 && $urandom_range(0, 1) == 1) begin
                t = w;
                w = h;
                h = t;
            end
            maxv = MAXVAL_OK;
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0: maxv = 0;
                    1: maxv = MAXVAL_OK - 1;
                    2: maxv = MAXVAL_OK + 1;
                    3: maxv = 65535;
                    default: maxv = 99999999;
                endcase
            end
            if (forced_w >= 0) begin
                w = forced_w;
                h = 1;
                maxv = MAXVAL_OK;
            end
            push_text("P6", 1'b1);
            push_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 2) == 0) begin
                push_byte(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_LF);
                    push_byte(b, 1'b0);
                end
                push_byte(CH_LF, 1'b0);
            end
            repeat ($urandom_range(0, 2)) push_blank();
            push_decimal(w);
            if (forced_w < 0 && $urandom_range(0, 24) == 0)
                push_byte(bad_char(), 1'b0);
            repeat ($urandom_range(1, 3)) push_blank();
            push_decimal(h);
            repeat ($urandom_range(1, 3)) push_blank();
            push_decimal(maxv);
            push_blank();
            n = (w > MAX_DIM_DEFAULT || h > MAX_DIM_DEFAULT) ? 2 : w * h;
            cut = 3 * n;
            if (forced_w < 0 && $urandom_range(0, 9) == 0)
                cut = $urandom_range(0, cut);
            for (int k = 0; k < cut; k++) begin
                if (k % 3 == 0) begin
                    pick = $urandom_range(0, 9);
                    for (int c = 0; c < 3; c++)
                        trip[c] = (pick < 5) ? color_key[c] : 8'($urandom_range(0, 255));
                    // A near miss: one bit off in one component.
                    if (pick >= 3 && pick < 5) begin
                        t = $urandom_range(0, 2);
                        trip[t] = trip[t] ^ (8'd1 << $urandom_range(0, 7));
                    end
                end
                push_byte(trip[k % 3], 1'b0);
            end
        end
        if (forced_w < 0 && $urandom_range(0, 4) == 0)
            push_noise();
    endtask

    // Polled between edges so that the clocked processes have settled.
    task automatic wait_idle();
        @(negedge i_clk);
        while (file_bytes.size() != 0 || s_axis_tvalid || rgba_expect.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #(64'd80_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int stop_at;
        color_key[REG_KEY_RED] = KEY_RED_RESET;
        color_key[REG_KEY_GREEN] = KEY_GREEN_RESET;
        color_key[REG_KEY_BLUE] = KEY_BLUE_RESET;
        restart_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        verify_key_regs();

        // Directed files under the reset key.
        send_pace = PACE_RANDOM;
        recv_pace = PACE_RANDOM;
        push_text("Q", 1'b1);
        push_text("P5", 1'b1);
        push_text("P6 #\n1 1 255\n", 1'b1);
        // Pause in the middle of a file until the header has come out.
        wait_idle();
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Width digit right after the separator, and an empty image.
        push_text("P6\n0 2 255 ", 1'b1);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_color_key(8'h00, 8'h00, 8'h00);
                1: set_color_key(8'hFF, 8'hFF, 8'hFF);
                3: set_color_key(8'h00, 8'hFF, 8'h00);
                default: set_color_key(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)));
            endcase
            if (ph == 2) begin
                // A long single-row image at full rate while the receiver holds off.
                send_pace = PACE_FULL;
                recv_pace = PACE_FULL;
                make_file(FORCED_WIDTH);
                hold_go = 1'b1;
                wait_idle();
            end
            send_pace = t_pace'(ph % 3);
            recv_pace = t_pace'((ph + 1) % 3);
            stop_at = bytes_made + BYTES_PER_PHASE;
            while (bytes_made < stop_at)
                make_file(-1);
            wait_idle();
        end

        $display("Streamed %0d bytes under %0d color keys: %0d headers, %0d errors,",
                 bytes_taken, key_settings, n_headers, n_errors);
        $display("%0d pixels of which %0d keyed; %0d mismatches.",
                 n_pixels, n_keyed, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
